FILE: design/seven_segment_scan_driver_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment scan driver
// Both expect clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH

// pre holds at an edge, post must hold at the same edge
`define SSSD_ASSERT_IMPLY(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("sssd: implication check failed");

// pre holds at an edge, post must hold at the next edge
`define SSSD_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sssd: next-cycle check failed");

`endif

FILE: design/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg
// Types, constants and the segment table shared by the scan driver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sssd_pkg;

	localparam int DIGIT_COUNT = 8;
	localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int SUM_W       = $clog2(DIGIT_COUNT + 8);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BLANK_CODE = 8'hff;

	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_DEC2 = 2'd0,
		MODE_DEC3 = 2'd1,
		MODE_DEC4 = 2'd2,
		MODE_HEX  = 2'd3
	} digit_mode_t;

	// beat as accepted on the input channel
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] value;
		logic [2:0]  position;
		digit_mode_t mode;
		logic        blank;
	} sssd_item_t;

	// classified operation handed from front to back
	typedef struct packed {
		cmd_t             cmd;
		logic [2:0]       position;
		digit_mode_t      mode;
		logic             blank;
		logic [3:0][3:0]  digit;
	} sssd_op_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} sssd_qstat_t;

	// active-low segment code, bits g..a in 6..0, dp in 7
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'h0: c = 8'hc0;
			4'h1: c = 8'hf9;
			4'h2: c = 8'ha4;
			4'h3: c = 8'hb0;
			4'h4: c = 8'h99;
			4'h5: c = 8'h92;
			4'h6: c = 8'h82;
			4'h7: c = 8'hf8;
			4'h8: c = 8'h80;
			4'h9: c = 8'h90;
			4'ha: c = 8'h88;
			4'hb: c = 8'h83;
			4'hc: c = 8'hc6;
			4'hd: c = 8'ha1;
			4'he: c = 8'h86;
			4'hf: c = 8'h8e;
			default: c = BLANK_CODE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/seven_segment_scan_driver_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top
// Eight-digit multiplexed seven-segment driver with a write and a tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries command beats. tuser 0 writes a number into the digit buffer
//   (2, 3 or 4 decimal digits or two hex nibbles, optional leading-zero
//   blanking) and returns nothing; tuser 1 is a scan tick and returns one
//   m_* beat with the one-hot digit select and the inverted segment byte of
//   the current scan position, which then advances modulo eight.
//   Throughput: one beat per cycle while m_tready holds no stall, with a
//   four-stage digit pipeline in front and one queue entry retired per cycle
//   in the back. A tick passes s1..s4, the queue and the output register to
//   m_*; a write is visible to ticks accepted after it; all beats keep order.
//   A stalled m_tready fills the output register, then the two-entry queue,
//   then the front pipeline, and s_tready falls; a tick waiting at the head
//   of the queue holds the writes queued behind it.
//   Reset (arst_n low) blanks all digits, sets scan position zero and
//   empties pipeline and queue; no clearing pass follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_scan_driver_top_assert.svh"

module seven_segment_scan_driver_top import sssd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // value[15:0], position[18:16], digit_mode[20:19],
	                                    // blank_leading[21], zero[23:22]
	input  wire logic        s_tuser,   // cmd[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // digit_select[7:0], segment_drive[15:8]
);

	sssd_item_t  in_item;
	logic        front_valid;
	sssd_op_t    front_op;
	sssd_op_t    fifo_head;
	sssd_qstat_t fifo_stat;
	logic        fifo_pop;
	logic [7:0]  digit_select, segment_drive;

	always_comb begin
		in_item.cmd      = cmd_t'(s_tuser);
		in_item.value    = s_tdata[15:0];
		in_item.position = s_tdata[18:16];
		in_item.mode     = digit_mode_t'(s_tdata[20:19]);
		in_item.blank    = s_tdata[21];
	end

	sssd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.queue_full (fifo_stat.full),
		.out_valid  (front_valid),
		.out_op     (front_op)
	);

	sssd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_valid),
		.push_op (front_op),
		.pop     (fifo_pop),
		.head    (fifo_head),
		.stat    (fifo_stat)
	);

	sssd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (fifo_head),
		.head_valid    (fifo_stat.not_empty),
		.pop           (fifo_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.digit_select  (digit_select),
		.segment_drive (segment_drive)
	);

	assign m_tdata = {segment_drive, digit_select};

	// a tick only leaves the queue into a free or draining output slot
	`SSSD_ASSERT_IMPLY(a_tick_slot_free, fifo_pop && (fifo_head.cmd == CMD_TICK), !m_tvalid || m_tready)
	// a retired tick is on the output in the next cycle
	`SSSD_ASSERT_NEXT(a_tick_shown, fifo_pop && (fifo_head.cmd == CMD_TICK), m_tvalid)
	// input back-pressure comes only from a full queue
	`SSSD_ASSERT_IMPLY(a_stall_cause, !s_tready, fifo_stat.full)
	// at most one digit selected
	`SSSD_ASSERT_IMPLY(a_select_onehot, m_tvalid, $onehot0(m_tdata[7:0]))

endmodule

`default_nettype wire

FILE: design/sssd_front.sv
// ----------------------------------------------------------------------------
// sssd_front
// Accepts beats and splits the value into four decimal digits over a short
// pipeline, one reciprocal multiply per stage, or takes two hex nibbles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sssd_front import sssd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire sssd_item_t  in_item,
	input  wire logic        queue_full,
	output logic             out_valid,
	output sssd_op_t         out_op
);

	logic        adv;
	logic        v_s1, v_s2, v_s3, v_s4;
	sssd_item_t  item_s1, item_s2, item_s3, item_s4;
	logic [12:0] q1_s2;
	logic [9:0]  q2_s3;
	logic [6:0]  q3_s4;
	logic [3:0]  d0_s2, d0_s3, d0_s4;
	logic [3:0]  d1_s3, d1_s4;
	logic [3:0]  d2_s4;

	logic [32:0] p1;
	logic [12:0] q1;
	logic [15:0] r0;
	logic [28:0] p2;
	logic [9:0]  q2;
	logic [12:0] r1;
	logic [17:0] p3;
	logic [6:0]  q3;
	logic [9:0]  r2;
	logic [14:0] p4;
	logic [3:0]  q4;
	logic [6:0]  r3;

	// hold the whole pipeline while the last stage cannot enter the queue
	assign adv      = !(v_s4 && queue_full);
	assign in_ready = adv;

	// x / 10 exact for 16-bit x
	assign p1 = {17'b0, item_s1.value} * 33'd52429;
	assign q1 = p1[31:19];
	assign r0 = item_s1.value - (({3'b0, q1} << 3) + ({3'b0, q1} << 1));

	assign p2 = {16'b0, q1_s2} * 29'd52429;
	assign q2 = p2[28:19];
	assign r1 = q1_s2 - (({3'b0, q2} << 3) + ({3'b0, q2} << 1));

	// small quotients: x * 205 >> 11 is exact below 1029
	assign p3 = {8'b0, q2_s3} * 18'd205;
	assign q3 = p3[17:11];
	assign r2 = q2_s3 - (({3'b0, q3} << 3) + ({3'b0, q3} << 1));

	assign p4 = {8'b0, q3_s4} * 15'd205;
	assign q4 = p4[14:11];
	assign r3 = q3_s4 - (({3'b0, q4} << 3) + ({3'b0, q4} << 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			item_s2 <= item_s1;
			q1_s2   <= q1;
			d0_s2   <= r0[3:0];
			item_s3 <= item_s2;
			q2_s3   <= q2;
			d0_s3   <= d0_s2;
			d1_s3   <= r1[3:0];
			item_s4 <= item_s3;
			q3_s4   <= q3;
			d0_s4   <= d0_s3;
			d1_s4   <= d1_s3;
			d2_s4   <= r2[3:0];
		end
	end

	always_comb begin
		out_op.cmd      = item_s4.cmd;
		out_op.position = item_s4.position;
		out_op.mode     = item_s4.mode;
		out_op.blank    = item_s4.blank;
		if (item_s4.mode == MODE_HEX) begin
			out_op.digit[0] = item_s4.value[3:0];
			out_op.digit[1] = item_s4.value[7:4];
			out_op.digit[2] = 4'd0;
			out_op.digit[3] = 4'd0;
		end else begin
			out_op.digit[0] = d0_s4;
			out_op.digit[1] = d1_s4;
			out_op.digit[2] = d2_s4;
			out_op.digit[3] = r3[3:0];
		end
	end

	assign out_valid = v_s4;

endmodule

`default_nettype wire

FILE: design/sssd_fifo.sv
// ----------------------------------------------------------------------------
// sssd_fifo
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sssd_fifo import sssd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire sssd_op_t  push_op,
	input  wire logic      pop,
	output sssd_op_t       head,
	output sssd_qstat_t    stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sssd_op_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.not_empty = (count_q != '0);
	assign do_push        = push && !stat.full;
	assign do_pop         = pop && stat.not_empty;
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

FILE: design/sssd_back.sv
// ----------------------------------------------------------------------------
// sssd_back
// Digit buffer, scan counter and output register: writes store segment
// codes, ticks read the current digit into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sssd_back import sssd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sssd_op_t  head,
	input  wire logic      head_valid,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     digit_select,
	output logic [7:0]     segment_drive
);

	logic [7:0]       codes_q [DIGIT_COUNT];
	logic [IDX_W-1:0] scan_q;
	logic             out_valid_q;
	logic [7:0]       select_q, segment_q;

	logic             do_write, do_tick;
	logic [2:0]       n_digits;
	logic [3:0]       blanked;
	logic [3:0]       wr_en;
	logic [SUM_W-1:0] wr_addr [4];
	logic [7:0]       wr_code [4];
	logic             all_zero;

	assign do_write = head_valid && (head.cmd == CMD_WRITE);
	assign do_tick  = head_valid && (head.cmd == CMD_TICK) && (!out_valid_q || out_ready);
	assign pop      = do_write || do_tick;

	always_comb begin
		n_digits = (head.mode == MODE_HEX) ? 3'd2 : {1'b0, head.mode} + 3'd2;
		// blank zeros from the top digit down, never the lowest digit
		all_zero = 1'b1;
		blanked  = '0;
		for (int i = 3; i >= 1; i--) begin
			if (3'(i) < n_digits) begin
				all_zero   = all_zero && (head.digit[i] == 4'd0);
				blanked[i] = head.blank && all_zero;
			end
		end
		for (int i = 0; i < 4; i++) begin
			wr_addr[i] = SUM_W'(head.position) + SUM_W'(i);
			wr_en[i]   = do_write && (3'(i) < n_digits) &&
			             (wr_addr[i] < SUM_W'(DIGIT_COUNT));
			wr_code[i] = blanked[i] ? BLANK_CODE : seg_code(head.digit[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIGIT_COUNT; j++) begin
				codes_q[j] <= BLANK_CODE;
			end
		end else begin
			for (int j = 0; j < DIGIT_COUNT; j++) begin
				for (int i = 0; i < 4; i++) begin
					if (wr_en[i] && (wr_addr[i] == SUM_W'(j))) begin
						codes_q[j] <= wr_code[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_tick) begin
				scan_q      <= (scan_q == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			select_q  <= (SUM_W'(scan_q) < SUM_W'(8)) ? (8'h80 >> scan_q) : 8'h00;
			segment_q <= ~codes_q[scan_q];
		end
	end

	assign out_valid     = out_valid_q;
	assign digit_select  = select_q;
	assign segment_drive = segment_q;

endmodule

`default_nettype wire
